@@ src/fbed_pkg.sv @@
// Package for the band-pass envelope detector: field widths, word codes,
// controller states and the command and status groups between the modules.
// No dependencies.
`default_nettype none

package fbed_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned ENV_W    = 32;
  localparam int unsigned TAPS_W   = 6;
  localparam int unsigned TDATA_W  = 24;
  localparam int unsigned TUSER_W  = 2;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_AUDIO       = 2'd0,
    OP_LOAD_BAND   = 2'd1,
    OP_LOAD_SMOOTH = 2'd2,
    OP_NONE        = 2'd3
  } fbed_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAND,
    ST_BAND_DRAIN,
    ST_SMOOTH,
    ST_SMOOTH_DRAIN
  } fbed_state_e;

  typedef struct packed {
    logic load_band;
    logic load_smooth;
    logic start_band;
    logic start_smooth;
    logic step;
    logic load_out;
  } fbed_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_empty;
  } fbed_status_t;

endpackage

`default_nettype wire

@@ src/fbed_ctrl.sv @@
// Controller of the envelope detector: sequences coefficient loads and the
// two filter passes of each audio word. Depends on fbed_pkg.
`default_nettype none

module fbed_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire fbed_pkg::fbed_op_e    in_op_i,
  input  wire logic                  out_free_i,
  input  wire fbed_pkg::fbed_status_t status_i,
  output fbed_pkg::fbed_cmd_t        cmd_o,
  output logic                       in_ready_o
);
  import fbed_pkg::*;

  fbed_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_op_i == OP_AUDIO) begin
          state_d = ST_BAND;
        end
      end
      ST_BAND: begin
        if (status_i.last_tap) begin
          state_d = ST_BAND_DRAIN;
        end
      end
      ST_BAND_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        if (status_i.last_tap) begin
          state_d = ST_SMOOTH_DRAIN;
        end
      end
      ST_SMOOTH_DRAIN: begin
        if (status_i.pipe_empty && out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OP_AUDIO:       cmd_o.start_band  = 1'b1;
            OP_LOAD_BAND:   cmd_o.load_band   = 1'b1;
            OP_LOAD_SMOOTH: cmd_o.load_smooth = 1'b1;
            default:        cmd_o             = '0;
          endcase
        end
      end
      ST_BAND: begin
        cmd_o.step = 1'b1;
      end
      ST_BAND_DRAIN: begin
        cmd_o.start_smooth = status_i.pipe_empty;
      end
      ST_SMOOTH: begin
        cmd_o.step = 1'b1;
      end
      ST_SMOOTH_DRAIN: begin
        cmd_o.load_out = status_i.pipe_empty && out_free_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/fbed_dp.sv @@
// Datapath of the envelope detector: delay lines, coefficient memories,
// tap counter and the shared rounding multiply-accumulate. Depends on fbed_pkg.
`default_nettype none

module fbed_dp #(
  parameter int unsigned MAX_TAPS = 32,
  parameter int unsigned IDXW     = $clog2(MAX_TAPS),
  parameter int unsigned NW       = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fbed_pkg::fbed_cmd_t          cmd_i,
  input  wire logic [NW-1:0]                taps_i,
  input  wire logic [fbed_pkg::IDX_W-1:0]   idx_i,
  input  wire logic signed [fbed_pkg::VALUE_W-1:0] value_i,
  output fbed_pkg::fbed_status_t            status_o,
  output logic signed [fbed_pkg::ENV_W-1:0] acc_o
);
  import fbed_pkg::*;

  logic signed [VALUE_W-1:0] band_hist_mem   [MAX_TAPS];
  logic signed [VALUE_W-1:0] smooth_hist_mem [MAX_TAPS];
  logic signed [VALUE_W-1:0] band_coef_mem   [MAX_TAPS];
  logic signed [VALUE_W-1:0] smooth_coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]       band_vld_q, smooth_vld_q;

  logic [IDXW-1:0] band_pos_q, smooth_pos_q;
  logic [IDXW-1:0] band_eff, smooth_eff, band_next, smooth_next;
  logic [IDXW-1:0] wr_pos_q, tap_q, coef_addr, coef_wr_addr;
  logic [NW-1:0]   k_n;
  logic            coef_ok, sel_q;

  logic signed [VALUE_W-1:0] band_x_q, band_h_q, smooth_x_q, smooth_h_q;
  logic                      band_v_q, smooth_v_q, rd_v_q, mul_v_q;
  logic signed [VALUE_W-1:0] x_sel, h_sel, rect;
  logic signed [ENV_W-1:0]   prod, mul_q, acc_q, acc_sat, acc_rnd;
  logic signed [ENV_W:0]     sum1, sum2;

  assign band_eff  = ({1'b0, band_pos_q} >= (IDXW + 1)'(taps_i)) ? '0 : band_pos_q;
  assign smooth_eff = ({1'b0, smooth_pos_q} >= (IDXW + 1)'(taps_i)) ? '0 : smooth_pos_q;
  assign band_next  = ((NW'(band_eff) + NW'(1)) >= taps_i) ? '0 : band_eff + IDXW'(1);
  assign smooth_next = ((NW'(smooth_eff) + NW'(1)) >= taps_i) ? '0 : smooth_eff + IDXW'(1);

  assign k_n = (tap_q <= wr_pos_q) ? (NW'(wr_pos_q) - NW'(tap_q))
                                   : (NW'(wr_pos_q) + taps_i - NW'(tap_q));
  assign coef_addr    = k_n[IDXW-1:0];
  assign coef_wr_addr = IDXW'(idx_i);
  assign coef_ok      = (32'(idx_i) < MAX_TAPS);

  always_comb begin
    if (acc_q[ENV_W-1:ENV_W-VALUE_W] == {1'b1, {(VALUE_W-1){1'b0}}}) begin
      rect = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (acc_q[ENV_W-1]) begin
      rect = -acc_q[ENV_W-1:ENV_W-VALUE_W];
    end else begin
      rect = acc_q[ENV_W-1:ENV_W-VALUE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_band) begin
      band_hist_mem[band_eff] <= value_i;
    end
    band_x_q <= band_hist_mem[tap_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_smooth) begin
      smooth_hist_mem[smooth_eff] <= rect;
    end
    smooth_x_q <= smooth_hist_mem[tap_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_band && coef_ok) begin
      band_coef_mem[coef_wr_addr] <= value_i;
    end
    band_h_q <= band_coef_mem[coef_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_smooth && coef_ok) begin
      smooth_coef_mem[coef_wr_addr] <= value_i;
    end
    smooth_h_q <= smooth_coef_mem[coef_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_vld_q   <= '0;
      smooth_vld_q <= '0;
      band_pos_q   <= '0;
      smooth_pos_q <= '0;
      tap_q        <= '0;
      wr_pos_q     <= '0;
      sel_q        <= 1'b0;
      rd_v_q       <= 1'b0;
      mul_v_q      <= 1'b0;
      band_v_q     <= 1'b0;
      smooth_v_q   <= 1'b0;
    end else begin
      rd_v_q     <= cmd_i.step;
      mul_v_q    <= rd_v_q;
      band_v_q   <= band_vld_q[tap_q];
      smooth_v_q <= smooth_vld_q[tap_q];
      if (cmd_i.start_band) begin
        band_vld_q[band_eff] <= 1'b1;
        band_pos_q           <= band_next;
        wr_pos_q             <= band_eff;
        tap_q                <= '0;
        sel_q                <= 1'b0;
      end else if (cmd_i.start_smooth) begin
        smooth_vld_q[smooth_eff] <= 1'b1;
        smooth_pos_q             <= smooth_next;
        wr_pos_q                 <= smooth_eff;
        tap_q                    <= '0;
        sel_q                    <= 1'b1;
      end else if (cmd_i.step && !status_o.last_tap) begin
        tap_q <= tap_q + IDXW'(1);
      end
    end
  end

  assign x_sel = sel_q ? (smooth_v_q ? smooth_x_q : '0) : (band_v_q ? band_x_q : '0);
  assign h_sel = sel_q ? smooth_h_q : band_h_q;
  assign prod  = ENV_W'(x_sel) * ENV_W'(h_sel);

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      if (x_sel == {1'b1, {(VALUE_W-1){1'b0}}} && h_sel == {1'b1, {(VALUE_W-1){1'b0}}}) begin
        mul_q <= {1'b0, {(ENV_W-1){1'b1}}};
      end else begin
        mul_q <= {prod[ENV_W-2:0], 1'b0};
      end
    end
  end

  assign sum1    = {acc_q[ENV_W-1], acc_q} + {mul_q[ENV_W-1], mul_q};
  assign acc_sat = (sum1[ENV_W] != sum1[ENV_W-1])
                 ? {sum1[ENV_W], {(ENV_W-1){~sum1[ENV_W]}}} : sum1[ENV_W-1:0];
  assign sum2    = {acc_sat[ENV_W-1], acc_sat} + (ENV_W + 1)'(32'h8000);
  assign acc_rnd = (sum2[ENV_W] != sum2[ENV_W-1])
                 ? {sum2[ENV_W], {(ENV_W-1){~sum2[ENV_W]}}} : sum2[ENV_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_band || cmd_i.start_smooth) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= {acc_rnd[ENV_W-1:VALUE_W], {VALUE_W{1'b0}}};
    end
  end

  assign status_o.last_tap   = ((NW'(tap_q) + NW'(1)) >= taps_i);
  assign status_o.pipe_empty = !rd_v_q && !mul_v_q;
  assign acc_o               = acc_q;

endmodule

`default_nettype wire

@@ src/fir_band_envelope_detector_top.sv @@
// Top level of the band-pass FIR envelope detector: tap count register,
// result register and the controller and datapath. Depends on fbed_pkg,
// fbed_ctrl and fbed_dp.
//
//   port group      dir   word contents
//   s_axis_*        in    one audio sample or one coefficient load
//   m_axis_*        out   one envelope value per audio sample
//   cfg_*           in    number of active taps
//
// An audio word occupies the block while one shared multiply-accumulate walks
// both filters in turn, with a pipeline drain after each, and no new word is
// accepted until its envelope is registered for output. A result not yet taken
// holds the last drain. Reset clears both delay lines, the write positions and
// sets the tap count to 32; coefficient memories start undefined.
`default_nettype none

module fir_band_envelope_detector_top #(
  parameter int unsigned MAX_TAPS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // coef_index [4:0], value [20:5], zero [23:21]
  input  wire logic [fbed_pkg::TDATA_W-1:0]    s_axis_tdata,
  // operation [1:0]
  input  wire logic [fbed_pkg::TUSER_W-1:0]    s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // envelope [31:0]
  output logic [fbed_pkg::ENV_W-1:0]           m_axis_tdata,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fbed_pkg::TAPS_W-1:0]     cfg_data_i
);
  import fbed_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_TAPS);
  localparam int unsigned NW   = $clog2(MAX_TAPS + 1);

  logic [TAPS_W-1:0]        taps_q;
  logic [NW-1:0]            taps_n;
  logic                     m_valid_q;
  logic [ENV_W-1:0]         m_data_q;
  logic                     out_free;
  logic                     in_ready;
  fbed_op_e                 in_op;
  fbed_cmd_t                cmd;
  fbed_status_t             status;
  logic signed [ENV_W-1:0]  acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RESET;
    end else if (cfg_valid_i) begin
      taps_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (taps_q == '0) begin
      taps_n = NW'(1);
    end else if (32'(taps_q) > MAX_TAPS) begin
      taps_n = NW'(MAX_TAPS);
    end else begin
      taps_n = NW'(taps_q);
    end
  end

  assign in_op    = fbed_op_e'(s_axis_tuser);
  assign out_free = !m_valid_q || m_axis_tready;

  fbed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (in_op),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  fbed_dp #(
    .MAX_TAPS (MAX_TAPS),
    .IDXW     (IDXW),
    .NW       (NW)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .taps_i   (taps_n),
    .idx_i    (s_axis_tdata[IDX_W-1:0]),
    .value_i  (s_axis_tdata[IDX_W+VALUE_W-1:IDX_W]),
    .status_o (status),
    .acc_o    (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      m_data_q <= acc;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
